[hw/rtl/baro_sensor_compensation_macros.svh]
// Assertion helpers for the compensation pipeline
`ifndef BARO_SENSOR_COMPENSATION_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_MACROS_SVH

`define BARO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define BARO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/baro_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package baro_pkg;

  localparam int unsigned WideW    = 224;
  localparam int unsigned LimbW    = 32;
  localparam int unsigned NumLimbs = WideW / LimbW;
  localparam int unsigned TlinW    = 60;
  localparam int unsigned XSplit   = TlinW / 2;
  localparam int unsigned RawW     = 24;
  localparam int unsigned CfgW     = 48;

  typedef logic [WideW-1:0]        wide_t;
  typedef logic signed [TlinW-1:0] tlin_t;
  typedef logic signed [LimbW-1:0] narrow_t;

  typedef enum logic [1:0] {
    CfgTempCal   = 2'd0,
    CfgPressLow  = 2'd1,
    CfgPressMid  = 2'd2,
    CfgPressHigh = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] temperature_out;
    logic [23:0]        pressure_out;
    logic               result_error;
  } out_word_t;

  // Offset that undoes the top-bit flip of every signed limb product
  function automatic wide_t mul_bias();
    wide_t r;
    r = '0;
    for (int k = 0; k < NumLimbs; k++) begin
      r = r + (wide_t'(1) << (2 * LimbW - 1 + LimbW * k));
    end
    return ~r + wide_t'(1);
  endfunction

  localparam wide_t MulBias = mul_bias();

  localparam logic signed [27:0] TqMax = 28'sd8388607;
  localparam logic signed [27:0] TqMin = -28'sd8388608;

  localparam int unsigned PressLsb = 175;
  localparam int unsigned PressW   = 24;
  localparam int unsigned SignBit  = WideW - 1;

endpackage

`default_nettype wire

[hw/rtl/baro_wmul.sv]
`timescale 1ns / 1ps
`default_nettype none

module baro_wmul (
  input  logic              clk_i,
  input  logic              en_i,
  input  baro_pkg::wide_t   a_i,
  input  baro_pkg::narrow_t b_i,
  output baro_pkg::wide_t   p_o
);

  logic signed [2*baro_pkg::LimbW-1:0] part_d [baro_pkg::NumLimbs];
  logic signed [2*baro_pkg::LimbW-1:0] part_q [baro_pkg::NumLimbs];
  logic [2*baro_pkg::LimbW-1:0]        flip   [baro_pkg::NumLimbs];
  baro_pkg::wide_t                     even_w;
  baro_pkg::wide_t                     odd_w;
  baro_pkg::wide_t                     p_q;

  always_comb begin
    for (int k = 0; k < baro_pkg::NumLimbs; k++) begin
      part_d[k] = $signed({1'b0, a_i[k*baro_pkg::LimbW +: baro_pkg::LimbW]}) * b_i;
      flip[k]   = part_q[k] ^ {1'b1, {(2*baro_pkg::LimbW-1){1'b0}}};
    end
  end

  // even and odd limb products do not overlap inside their own rows
  assign even_w = {flip[6][baro_pkg::LimbW-1:0], flip[4], flip[2], flip[0]};
  assign odd_w  = {flip[5], flip[3], flip[1], {baro_pkg::LimbW{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_q <= part_d;
      p_q    <= even_w + odd_w + baro_pkg::MulBias;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[hw/rtl/baro_hstep.sv]
`timescale 1ns / 1ps
`default_nettype none

module baro_hstep (
  input  logic              clk_i,
  input  logic              en_i,
  input  baro_pkg::wide_t   acc_i,
  input  baro_pkg::tlin_t   x_i,
  input  baro_pkg::wide_t   add_i,
  output baro_pkg::wide_t   h_o
);

  baro_pkg::narrow_t x_lo;
  baro_pkg::narrow_t x_hi;
  baro_pkg::wide_t   p_lo;
  baro_pkg::wide_t   p_hi;
  baro_pkg::wide_t   h_q;

  assign x_lo = baro_pkg::narrow_t'({1'b0, x_i[baro_pkg::XSplit-1:0]});
  assign x_hi = baro_pkg::narrow_t'($signed(x_i[baro_pkg::TlinW-1:baro_pkg::XSplit]));

  baro_wmul u_mul_lo (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (acc_i),
    .b_i   (x_lo),
    .p_o   (p_lo)
  );

  baro_wmul u_mul_hi (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (acc_i),
    .b_i   (x_hi),
    .p_o   (p_hi)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q <= (p_hi << baro_pkg::XSplit) + p_lo + add_i;
    end
  end

  assign h_o = h_q;

endmodule

`default_nettype wire

[hw/rtl/baro_tlin.sv]
`timescale 1ns / 1ps
`default_nettype none

module baro_tlin (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [baro_pkg::RawW-1:0] raw_temperature_i,
  input  logic [39:0]               tcal_i,
  output baro_pkg::tlin_t           tl_o
);

  logic [15:0]        t1;
  logic [15:0]        t2;
  logic signed [7:0]  t3;
  logic signed [24:0] d_q;
  logic signed [41:0] m1_q;
  logic signed [41:0] m1b_q;
  logic signed [49:0] m2_q;
  logic signed [57:0] m3_q;
  baro_pkg::tlin_t    tl_q;

  assign t1 = tcal_i[15:0];
  assign t2 = tcal_i[31:16];
  assign t3 = $signed(tcal_i[39:32]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= $signed({1'b0, raw_temperature_i}) - $signed({1'b0, t1, 8'h00});
      m1_q  <= d_q * $signed({1'b0, t2});
      m2_q  <= d_q * d_q;
      m1b_q <= m1_q;
      m3_q  <= m2_q * t3;
      tl_q  <= (baro_pkg::tlin_t'(m1b_q) <<< 18) + baro_pkg::tlin_t'(m3_q);
    end
  end

  assign tl_o = tl_q;

endmodule

`default_nettype wire

[hw/rtl/baro_sensor_compensation.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "baro_sensor_compensation_macros.svh"

// Barometric compensation: takes one raw pressure/temperature word per cycle while
// in_stall_o is low and returns the linearised temperature (2^-16 degC) and the
// cubic-compensated pressure (2^-6 Pa), both computed exactly and floored, with an
// error flag for non-positive pressure or saturation. A word passes through the four
// temperature stages and two chained Horner steps, each a 3-stage multiply by the
// 60-bit temperature built from 32-bit limb multipliers, then a multiply of the
// Horner sum by the raw pressure. A two-entry output skid holds words under output
// stall; the input stalls while the skid's spare entry is full.
// Write calibration only while no word is in flight.
module baro_sensor_compensation (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  baro_pkg::in_word_t   in_word_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output baro_pkg::out_word_t  out_word_o,
  input  logic                 out_stall_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [baro_pkg::CfgW-1:0] cfg_wdata_i
);

  logic [39:0] tcal_q;
  logic [47:0] plow_q;
  logic [47:0] pmid_q;
  logic [31:0] phigh_q;

  logic signed [16:0] p1, p2;
  logic signed [7:0]  p3, p4, p7, p8, p10, p11;
  logic [15:0]        p5, p6;
  logic signed [15:0] p9;

  logic        en;
  logic        in_accept;
  logic [15:1] v_q;

  logic [baro_pkg::RawW-1:0] u_q [1:12];
  baro_pkg::tlin_t           tl;
  baro_pkg::tlin_t           x_q [5:9];
  logic signed [27:0]        tq_full;
  logic signed [23:0]        tq_d;
  logic                      terr_d;
  logic signed [23:0]        tq_q [5:15];
  logic                      terr_q [5:15];
  logic signed [67:0]        pr8_q, pr4_q, pr10_q;
  logic signed [32:0]        pr11_q;

  baro_pkg::wide_t h1a_q, h1b_q, c_q;
  baro_pkg::wide_t h2a, h2b, h3a, bsum;
  baro_pkg::wide_t uc;
  baro_pkg::wide_t uc_q [9:10];
  baro_pkg::wide_t addb_q;
  baro_pkg::wide_t a_q [13:14];
  baro_pkg::wide_t prod;
  baro_pkg::wide_t n_q;

  logic                n_zero, n_neg, n_sat;
  baro_pkg::out_word_t res;
  baro_pkg::out_word_t out_q;
  baro_pkg::out_word_t spare_q;
  logic                out_valid_q;
  logic                spare_full_q;
  logic                out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q  <= '0;
      plow_q  <= '0;
      pmid_q  <= '0;
      phigh_q <= '0;
    end else if (cfg_we_i) begin
      case (baro_pkg::cfg_idx_e'(cfg_idx_i))
        baro_pkg::CfgTempCal:   tcal_q  <= cfg_wdata_i[39:0];
        baro_pkg::CfgPressLow:  plow_q  <= cfg_wdata_i[47:0];
        baro_pkg::CfgPressMid:  pmid_q  <= cfg_wdata_i[47:0];
        baro_pkg::CfgPressHigh: phigh_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign p1  = $signed({plow_q[15], plow_q[15:0]}) - 17'sd16384;
  assign p2  = $signed({plow_q[31], plow_q[31:16]}) - 17'sd16384;
  assign p3  = $signed(plow_q[39:32]);
  assign p4  = $signed(plow_q[47:40]);
  assign p5  = pmid_q[15:0];
  assign p6  = pmid_q[31:16];
  assign p7  = $signed(pmid_q[39:32]);
  assign p8  = $signed(pmid_q[47:40]);
  assign p9  = $signed(phigh_q[15:0]);
  assign p10 = $signed(phigh_q[23:16]);
  assign p11 = $signed(phigh_q[31:24]);

  assign en         = !spare_full_q;
  assign in_stall_o = spare_full_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[14:1], in_accept};
    end
  end

  baro_tlin u_tlin (
    .clk_i             (clk_i),
    .en_i              (en),
    .raw_temperature_i (in_word_i.raw_temperature),
    .tcal_i            (tcal_q),
    .tl_o              (tl)
  );

  assign tq_full = tl[baro_pkg::TlinW-1:32];

  always_comb begin
    tq_d   = tq_full[23:0];
    terr_d = 1'b0;
    if (tq_full > baro_pkg::TqMax) begin
      tq_d   = baro_pkg::TqMax[23:0];
      terr_d = 1'b1;
    end else if (tq_full < baro_pkg::TqMin) begin
      tq_d   = baro_pkg::TqMin[23:0];
      terr_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q[1] <= in_word_i.raw_pressure;
      for (int k = 2; k <= 12; k++) begin
        u_q[k] <= u_q[k-1];
      end
      x_q[5] <= tl;
      for (int k = 6; k <= 9; k++) begin
        x_q[k] <= x_q[k-1];
      end
      tq_q[5]   <= tq_d;
      terr_q[5] <= terr_d;
      for (int k = 6; k <= 15; k++) begin
        tq_q[k]   <= tq_q[k-1];
        terr_q[k] <= terr_q[k-1];
      end
      pr8_q  <= p8 * tl;
      pr4_q  <= p4 * tl;
      pr10_q <= p10 * tl;
      pr11_q <= $signed({1'b0, u_q[4]}) * p11;
      h1a_q  <= baro_pkg::wide_t'(pr8_q) + (baro_pkg::wide_t'(p7) << 55);
      h1b_q  <= baro_pkg::wide_t'(pr4_q) + (baro_pkg::wide_t'(p3) << 53);
      c_q    <= (baro_pkg::wide_t'(pr10_q) << 85) + (baro_pkg::wide_t'(p9) << 133)
                + (baro_pkg::wide_t'(pr11_q) << 116);
      uc_q[9]  <= uc;
      uc_q[10] <= uc_q[9];
      addb_q   <= (baro_pkg::wide_t'(p1) << 161) + uc_q[10];
      a_q[13]  <= h3a << 22;
      a_q[14]  <= a_q[13];
      n_q      <= a_q[14] + prod;
    end
  end

  baro_wmul u_mul_uc (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (c_q),
    .b_i   (baro_pkg::narrow_t'({1'b0, u_q[6]})),
    .p_o   (uc)
  );

  baro_hstep u_step_a1 (
    .clk_i (clk_i),
    .en_i  (en),
    .acc_i (h1a_q),
    .x_i   (x_q[6]),
    .add_i (baro_pkg::wide_t'(p6) << 105),
    .h_o   (h2a)
  );

  baro_hstep u_step_b1 (
    .clk_i (clk_i),
    .en_i  (en),
    .acc_i (h1b_q),
    .x_i   (x_q[6]),
    .add_i (baro_pkg::wide_t'(p2) << 104),
    .h_o   (h2b)
  );

  baro_hstep u_step_a2 (
    .clk_i (clk_i),
    .en_i  (en),
    .acc_i (h2a),
    .x_i   (x_q[9]),
    .add_i (baro_pkg::wide_t'(p5) << 162),
    .h_o   (h3a)
  );

  baro_hstep u_step_b2 (
    .clk_i (clk_i),
    .en_i  (en),
    .acc_i (h2b),
    .x_i   (x_q[9]),
    .add_i (addb_q),
    .h_o   (bsum)
  );

  baro_wmul u_mul_ub (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (bsum),
    .b_i   (baro_pkg::narrow_t'({1'b0, u_q[12]})),
    .p_o   (prod)
  );

  assign n_zero = (n_q == '0);
  assign n_neg  = n_q[baro_pkg::SignBit];
  assign n_sat  = |n_q[baro_pkg::SignBit-1:baro_pkg::PressLsb+baro_pkg::PressW];

  always_comb begin
    res.temperature_out = tq_q[15];
    res.result_error    = terr_q[15] || n_zero || n_neg || n_sat;
    if (n_zero || n_neg) begin
      res.pressure_out = '0;
    end else if (n_sat) begin
      res.pressure_out = '1;
    end else begin
      res.pressure_out = n_q[baro_pkg::PressLsb +: baro_pkg::PressW];
    end
  end

  assign out_load = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      spare_full_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q  <= spare_full_q || v_q[15];
      spare_full_q <= 1'b0;
    end else if (en && v_q[15]) begin
      spare_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= spare_full_q ? spare_q : res;
    end
    if (!out_load && en && v_q[15]) begin
      spare_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `BARO_ASSERT_NOW(a_spare_has_out, spare_full_q, out_valid_q, "spare word without output word")
  `BARO_ASSERT_NEXT(a_pipe_holds, spare_full_q, $stable(v_q), "pipeline moved while skid full")
  `BARO_ASSERT_NEXT(a_word_enters, in_valid_i && !in_stall_o, v_q[1], "accepted word lost")

endmodule

`default_nettype wire
